[rtl/core/vnorm_pkg.sv]
package vnorm_pkg;

    // Fraction bits of the unit-vector result
    localparam int FRAC_BITS  = 16;
    localparam int COMP_W     = 32;
    localparam int SQ_W       = 2 * COMP_W;
    localparam int OUT_W      = FRAC_BITS + 2;
    localparam int ROOT_W     = FRAC_BITS + 1;
    // Holds 4 * k^2 * S and the scaled limit 4 * m^2 * 2^(2F)
    localparam int ACC_W      = SQ_W + 2 * FRAC_BITS + 4;
    localparam int IN_DATA_W  = 3 * COMP_W;
    localparam int OUT_DATA_W = ((3 * OUT_W + 7) / 8) * 8;

    // Pipeline: magnitude, square, sum, one stage per result bit, output
    localparam int N_ITER  = FRAC_BITS + 1;
    localparam int N_STAGE = N_ITER + 4;

endpackage

[rtl/core/vector3_normalize_unit.sv]
// vector3_normalize_unit
// Scales a 3D vector (signed Q16.16 per component) to unit length, giving
// signed Q1.FRAC_BITS components rounded to nearest, ties away from zero.
// Slave stream: i_s_tdata carries comp_x, comp_y, comp_z (32 bits each).
// Master stream: o_m_tdata carries unit_x, unit_y, unit_z; o_m_tuser is the
// zero_length flag, set (with all components zero) for a zero vector.
// Throughput is one transaction per cycle while the receiver does not stall:
// magnitudes, squares and the sum take a stage each, then one stage per
// result bit runs a restoring square-root style compare on shift-and-add
// terms, and a final stage applies the sign.
// Every stage holds its own valid bit and advances when the stage after it
// is empty or moving, so bubbles close up and a stalled receiver fills the
// pipe before o_s_tready falls; nothing is dropped or repeated.
// Reset (i_rst_n low, synchronous) clears all valid bits; data is not reset.
module vector3_normalize_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // comp_x [31:0], comp_y [63:32], comp_z [95:64]
    input  logic [vnorm_pkg::IN_DATA_W-1:0]    i_s_tdata,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // unit_x, unit_y, unit_z from bit 0 up, OUT_W each, zero padded
    output logic [vnorm_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    // zero_length
    output logic                               o_m_tuser
);
    import vnorm_pkg::*;

    // Stage valids and advance enables
    logic [N_STAGE-1:0] r_vld;
    logic [N_STAGE-1:0] en;

    always_comb begin
        en[N_STAGE-1] = !r_vld[N_STAGE-1] || i_m_tready;
        for (int i = N_STAGE - 2; i >= 0; i--) begin
            en[i] = !r_vld[i] || en[i+1];
        end
    end

    assign o_s_tready = en[0];
    assign o_m_tvalid = r_vld[N_STAGE-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_s_tvalid;
            end
            for (int i = 1; i < N_STAGE; i++) begin
                if (en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    // Stage 0: magnitudes and signs
    logic [COMP_W-1:0] r_mag [3];
    logic [2:0]        r_neg0;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int l = 0; l < 3; l++) begin
                r_neg0[l] <= i_s_tdata[l*COMP_W + COMP_W-1];
                r_mag[l]  <= i_s_tdata[l*COMP_W + COMP_W-1]
                           ? COMP_W'(-i_s_tdata[l*COMP_W +: COMP_W])
                           : i_s_tdata[l*COMP_W +: COMP_W];
            end
        end
    end

    // Stage 1: squares
    logic [SQ_W-1:0] r_sq [3];
    logic [2:0]      r_neg1;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_neg1 <= r_neg0;
            for (int l = 0; l < 3; l++) begin
                r_sq[l] <= SQ_W'(r_mag[l]) * SQ_W'(r_mag[l]);
            end
        end
    end

    // Iteration state, index 0 is the sum stage, index j+1 follows bit stage j
    logic [SQ_W-1:0]   r_ss   [N_ITER+1];
    logic              r_zero [N_ITER+1];
    logic [2:0]        r_neg  [N_ITER+1];
    logic [ROOT_W-1:0] r_rr   [N_ITER+1][3];
    logic [ACC_W-1:0]  r_aa   [N_ITER+1][3];
    logic [ACC_W-1:0]  r_bb   [N_ITER+1][3];
    logic [ACC_W-1:0]  r_lim  [N_ITER+1][3];

    // Stage 2: squared length and per-lane limits
    logic [SQ_W-1:0] n_sum;
    assign n_sum = r_sq[0] + r_sq[1] + r_sq[2];

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_ss[0]   <= n_sum;
            r_zero[0] <= (n_sum == '0);
            r_neg[0]  <= r_neg1;
            for (int l = 0; l < 3; l++) begin
                r_rr[0][l]  <= '0;
                r_aa[0][l]  <= '0;
                r_bb[0][l]  <= '0;
                r_lim[0][l] <= ACC_W'(r_sq[l]) << (2 * FRAC_BITS + 2);
            end
        end
    end

    // Bit stages: try k = r | 2^b, keep it if (2k-1)^2 * S <= 4 m^2 2^(2F)
    // A tracks r^2 * S and B tracks r * S so only shifts and adds are needed
    genvar j, l;
    generate
        for (j = 0; j < N_ITER; j++) begin : g_bit
            localparam int BIT = FRAC_BITS - j;
            for (l = 0; l < 3; l++) begin : g_lane
                logic [ACC_W-1:0]  n_ext;
                logic [ACC_W-1:0]  n_ksq;
                logic [ACC_W-1:0]  n_ks;
                logic [ACC_W-1:0]  n_test;
                logic              n_ok;

                always_comb begin
                    n_ext  = ACC_W'(r_ss[j]);
                    n_ksq  = r_aa[j][l] + (r_bb[j][l] << (BIT + 1)) + (n_ext << (2 * BIT));
                    n_ks   = r_bb[j][l] + (n_ext << BIT);
                    n_test = (n_ksq << 2) - (n_ks << 2) + n_ext;
                    n_ok   = !r_rr[j][l][ROOT_W-1] && (n_test <= r_lim[j][l]);
                end

                always_ff @(posedge i_clk) begin
                    if (en[3+j]) begin
                        r_lim[j+1][l] <= r_lim[j][l];
                        if (n_ok) begin
                            r_rr[j+1][l] <= r_rr[j][l] | (ROOT_W'(1) << BIT);
                            r_aa[j+1][l] <= n_ksq;
                            r_bb[j+1][l] <= n_ks;
                        end else begin
                            r_rr[j+1][l] <= r_rr[j][l];
                            r_aa[j+1][l] <= r_aa[j][l];
                            r_bb[j+1][l] <= r_bb[j][l];
                        end
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (en[3+j]) begin
                    r_ss[j+1]   <= r_ss[j];
                    r_zero[j+1] <= r_zero[j];
                    r_neg[j+1]  <= r_neg[j];
                end
            end
        end
    endgenerate

    // Output stage: sign and zero-vector handling
    logic [OUT_W-1:0] r_unit [3];
    logic             r_zflag;

    always_ff @(posedge i_clk) begin
        if (en[N_STAGE-1]) begin
            r_zflag <= r_zero[N_ITER];
            for (int i = 0; i < 3; i++) begin
                if (r_zero[N_ITER]) begin
                    r_unit[i] <= '0;
                end else if (r_neg[N_ITER][i]) begin
                    r_unit[i] <= OUT_W'(-OUT_W'(r_rr[N_ITER][i]));
                end else begin
                    r_unit[i] <= OUT_W'(r_rr[N_ITER][i]);
                end
            end
        end
    end

    always_comb begin
        o_m_tdata = '0;
        for (int i = 0; i < 3; i++) begin
            o_m_tdata[i*OUT_W +: OUT_W] = r_unit[i];
        end
    end

    assign o_m_tuser = r_zflag;

    // Input only blocks when the whole pipe is full and the receiver stalls
    a_ready_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready && (&r_vld)))
        else $error("input stalled with room in pipeline");

    // Zero vector gives all-zero components
    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (r_unit[0] == '0 && r_unit[1] == '0
                                       && r_unit[2] == '0))
        else $error("zero-length result with non-zero component");

    // Root never exceeds one in magnitude
    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[N_STAGE-2] |-> (r_rr[N_ITER][0] <= (ROOT_W'(1) << FRAC_BITS)
                              && r_rr[N_ITER][1] <= (ROOT_W'(1) << FRAC_BITS)
                              && r_rr[N_ITER][2] <= (ROOT_W'(1) << FRAC_BITS)))
        else $error("scaled component above unity");

endmodule

[tb/vector3_normalize_unit_tb.sv]
module vector3_normalize_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vnorm_pkg::*;

    typedef struct packed {
        logic signed [COMP_W-1:0] z;
        logic signed [COMP_W-1:0] y;
        logic signed [COMP_W-1:0] x;
    } t_vec;

    typedef struct {
        logic [OUT_W-1:0] ux;
        logic [OUT_W-1:0] uy;
        logic [OUT_W-1:0] uz;
        logic             zero_len;
    } t_unit;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tuser;
    // Input transaction seen at the last rising edge
    logic                  o_s_tready_q;

    t_vec  vec_pending[$];
    t_unit unit_expected[$];
    int    send_idle_pct;
    int    recv_idle_pct;
    int    hold_cycles;
    bit    stim_done;
    bit    failed;

    vector3_normalize_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Magnitude of a two's complement component; -2^31 fits in 33 bits
    function automatic logic [COMP_W:0] comp_mag(logic signed [COMP_W-1:0] c);
        logic signed [COMP_W:0] w;
        w = (COMP_W+1)'(c);
        return (w < 0) ? -w : w;
    endfunction

    // Largest k <= 2^F with (2k-1)^2 * S <= 4 * m^2 * 2^(2F): nearest, ties away
    function automatic logic [ROOT_W-1:0] unit_mag(logic [COMP_W:0] m,
                                                   logic [SQ_W-1:0] s);
        logic [ACC_W+8-1:0] lim;
        logic [ACC_W+8-1:0] lhs;
        logic [ROOT_W:0]    r;
        logic [ROOT_W:0]    k;
        logic [ROOT_W+1:0]  odd;
        lim = ({{(ACC_W+8-COMP_W-1){1'b0}}, m} * m) << (2 * FRAC_BITS + 2);
        r = '0;
        for (int b = FRAC_BITS; b >= 0; b--) begin
            k = r | ((ROOT_W+1)'(1) << b);
            if (k <= (1 << FRAC_BITS)) begin
                odd = {k, 1'b0} - 1'b1;
                lhs = {{(ACC_W+8-ROOT_W-2){1'b0}}, odd};
                lhs = lhs * lhs * s;
                if (lhs <= lim) r = k;
            end
        end
        return r[ROOT_W-1:0];
    endfunction

    function automatic t_unit normalise(t_vec v);
        t_unit            u;
        logic [COMP_W:0]  mx, my, mz;
        logic [SQ_W-1:0]  s;
        logic [OUT_W-1:0] r;
        mx = comp_mag(v.x);
        my = comp_mag(v.y);
        mz = comp_mag(v.z);
        s = SQ_W'(mx * mx) + SQ_W'(my * my) + SQ_W'(mz * mz);
        u.zero_len = (s == 0);
        u.ux = '0;
        u.uy = '0;
        u.uz = '0;
        if (s != 0) begin
            r = OUT_W'(unit_mag(mx, s));
            u.ux = v.x[COMP_W-1] ? -r : r;
            r = OUT_W'(unit_mag(my, s));
            u.uy = v.y[COMP_W-1] ? -r : r;
            r = OUT_W'(unit_mag(mz, s));
            u.uz = v.z[COMP_W-1] ? -r : r;
        end
        return u;
    endfunction

    // Random component biased towards interesting magnitudes
    function automatic logic [COMP_W-1:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 3) - 1;
            1: return $urandom() >> $urandom_range(0, 31);
            2: return -($urandom() >> $urandom_range(0, 31));
            3: return {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom())};
            default: return $urandom();
        endcase
    endfunction

    function automatic t_vec mk(logic [COMP_W-1:0] x, logic [COMP_W-1:0] y,
                                logic [COMP_W-1:0] z);
        t_vec v;
        v.x = x;
        v.y = y;
        v.z = z;
        return v;
    endfunction

    // Stimulus: directed extremes then random vectors
    initial begin
        t_vec v;
        vec_pending.push_back(mk(0, 0, 0));
        vec_pending.push_back(mk(32'h8000_0000, 0, 0));
        vec_pending.push_back(mk(0, 32'h7FFF_FFFF, 0));
        vec_pending.push_back(mk(0, 0, 32'h8000_0000));
        vec_pending.push_back(mk(0, 0, 1));
        vec_pending.push_back(mk(32'hFFFF_FFFF, 0, 0));
        vec_pending.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        vec_pending.push_back(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        vec_pending.push_back(mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
        vec_pending.push_back(mk(1, 1, 1));
        vec_pending.push_back(mk(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF));
        vec_pending.push_back(mk(3, 4, 0));
        vec_pending.push_back(mk(32'hFFFD_0000, 0, 32'h0004_0000));
        vec_pending.push_back(mk(1, 32'h7FFF_FFFF, 0));
        vec_pending.push_back(mk(32'h0001_0000, 32'h0002_0000, 32'h0002_0000));
        vec_pending.push_back(mk(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
        vec_pending.push_back(mk(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));
        for (int i = 0; i < 500; i++) begin
            v = mk(rand_comp(), rand_comp(), rand_comp());
            if ($urandom_range(0, 9) == 0) v.y = 0;
            if ($urandom_range(0, 19) == 0) v = mk(0, 0, 0);
            vec_pending.push_back(v);
        end
    end

    // Reset release, idling phases and one long receiver hold-off
    initial begin
        i_rst_n = 1'b0;
        send_idle_pct = 10;
        recv_idle_pct = 74;
        hold_cycles = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        wait (vec_pending.size() < 350);
        @(negedge i_clk);
        hold_cycles = 60;
        send_idle_pct = 0;
        wait (vec_pending.size() < 330);
        send_idle_pct = 74;
        recv_idle_pct = 10;
        wait (vec_pending.size() < 170);
        send_idle_pct = 0;
        recv_idle_pct = 0;
    end

    // Driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= '0;
        end else if (!i_s_tvalid || o_s_tready_q) begin
            if (vec_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= vec_pending.pop_front();
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Input transaction sampling and prediction
    always @(posedge i_clk) begin
        o_s_tready_q <= i_rst_n && i_s_tvalid && o_s_tready;
        if (i_rst_n && i_s_tvalid && o_s_tready)
            unit_expected.push_back(normalise(t_vec'(i_s_tdata)));
    end

    // Receiver back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            i_m_tready  <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        t_unit e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (unit_expected.size() == 0) begin
                $error("result with nothing expected: tdata %h", o_m_tdata);
                failed = 1'b1;
            end else begin
                e = unit_expected.pop_front();
                if (o_m_tdata[OUT_W-1:0] !== e.ux) begin
                    $error("unit_x expected %h got %h", e.ux, o_m_tdata[OUT_W-1:0]);
                    failed = 1'b1;
                end
                if (o_m_tdata[2*OUT_W-1:OUT_W] !== e.uy) begin
                    $error("unit_y expected %h got %h", e.uy,
                           o_m_tdata[2*OUT_W-1:OUT_W]);
                    failed = 1'b1;
                end
                if (o_m_tdata[3*OUT_W-1:2*OUT_W] !== e.uz) begin
                    $error("unit_z expected %h got %h", e.uz,
                           o_m_tdata[3*OUT_W-1:2*OUT_W]);
                    failed = 1'b1;
                end
                if (o_m_tuser !== e.zero_len) begin
                    $error("zero_length expected %b got %b", e.zero_len, o_m_tuser);
                    failed = 1'b1;
                end
            end
        end
    end

    // End of run
    initial begin
        failed = 1'b0;
        wait (i_rst_n && vec_pending.size() == 0);
        @(posedge i_clk);
        while (i_s_tvalid || unit_expected.size() != 0) @(posedge i_clk);
        repeat (4 * N_STAGE) @(posedge i_clk);
        if (!failed && unit_expected.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2ms;
        $display("FAIL");
        $finish;
    end

endmodule
